@@ sv/rmf_pkg.sv @@
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int WINDOW_DEF       = 9;
    localparam int SAMPLE_WIDTH_DEF = 16;

    typedef struct packed {
        logic valid;
        logic ge;
        logic evict_seen;
    } t_link;

endpackage

@@ sv/rmf_cell.sv @@
`timescale 1ns / 1ps

module rmf_cell #(
    parameter int WINDOW       = 9,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  rmf_pkg::t_link                 i_dn,
    input  logic signed [SAMPLE_WIDTH-1:0] i_dn_value,
    input  logic        [AW-1:0]           i_dn_age,
    input  logic                           i_up_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_up_value,
    input  logic        [AW-1:0]           i_up_age,
    output rmf_pkg::t_link                 o_dn,
    output logic signed [SAMPLE_WIDTH-1:0] o_dn_value,
    output logic        [AW-1:0]           o_dn_age,
    output logic                           o_up_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_up_value,
    output logic        [AW-1:0]           o_up_age,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);
    import rmf_pkg::*;

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic        [AW-1:0]           r_age;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic        [AW-1:0]           n_age;

    logic                           evict;
    logic                           shifted;
    logic                           c_valid;
    logic signed [SAMPLE_WIDTH-1:0] c_value;
    logic        [AW-1:0]           c_age;
    logic                           c_ge;

    always_comb begin
        evict   = i_full && r_valid && (r_age == AW'(WINDOW - 1));
        shifted = i_dn.evict_seen || evict;
        c_valid = shifted ? i_up_valid : r_valid;
        c_value = shifted ? i_up_value : r_value;
        c_age   = shifted ? i_up_age   : r_age;
        c_ge    = c_valid && (c_value >= i_sample);

        // keep own (or the up neighbor's after an eviction), take the new sample, or take the down neighbor's
        if (c_ge) begin
            n_valid = 1'b1;
            n_value = c_value;
            n_age   = c_age + AW'(1);
        end else if (i_dn.ge) begin
            n_valid = 1'b1;
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_valid = i_dn.valid;
            n_value = i_dn_value;
            n_age   = i_dn_age + AW'(1);
        end
    end

    assign o_dn.valid      = c_valid;
    assign o_dn.ge         = c_ge;
    assign o_dn.evict_seen = shifted;
    assign o_dn_value      = c_value;
    assign o_dn_age        = c_age;
    assign o_up_valid      = r_valid;
    assign o_up_value      = r_value;
    assign o_up_age        = r_age;
    assign o_next_value    = n_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

@@ sv/running_median_filter.sv @@
`timescale 1ns / 1ps

// channel   signals                        direction
// -------   ----------------------------   ---------
// sample    i_valid, o_ready, i_sample     in
// median    o_valid, i_ready, o_median     out
//
// One item per cycle while o_ready is high; the result is registered and appears in the cycle after acceptance.
// A row of WINDOW sorted cells inserts the new sample and, once full, drops the oldest
// in the same cycle; the evict flag ripples along the row and bounds the path.
// Reset clears the cell valid bits, the fill count and the output valid.
// A stalled result holds in the output register; o_ready falls only while it waits.

module running_median_filter #(
    parameter int WINDOW       = rmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);
    import rmf_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           accept;
    logic                           full;
    logic signed [SAMPLE_WIDTH-1:0] sample_adj;
    logic        [CW-1:0]           r_fill;
    logic        [CW-1:0]           n_fill;
    logic        [CW-1:0]           mid;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_median;

    t_link                          dn_link  [0:WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] dn_value [0:WINDOW];
    logic        [AW-1:0]           dn_age   [0:WINDOW];
    logic                           up_valid [0:WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] up_value [0:WINDOW];
    logic        [AW-1:0]           up_age   [0:WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] next_value [0:WINDOW-1];

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_fill == CW'(WINDOW));
    assign sample_adj = (i_sample == SMIN) ? (i_sample + SAMPLE_WIDTH'(1)) : i_sample;
    assign n_fill  = full ? r_fill : (r_fill + CW'(1));
    assign mid     = (n_fill - CW'(1)) >> 1;

    assign dn_link[0].valid      = 1'b1;
    assign dn_link[0].ge         = 1'b1;
    assign dn_link[0].evict_seen = 1'b0;
    assign dn_value[0]           = '0;
    assign dn_age[0]             = '0;
    assign up_valid[WINDOW]      = 1'b0;
    assign up_value[WINDOW]      = '0;
    assign up_age[WINDOW]        = '0;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        rmf_cell #(
            .WINDOW      (WINDOW),
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .AW          (AW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (accept),
            .i_full      (full),
            .i_sample    (sample_adj),
            .i_dn        (dn_link[g]),
            .i_dn_value  (dn_value[g]),
            .i_dn_age    (dn_age[g]),
            .i_up_valid  (up_valid[g+1]),
            .i_up_value  (up_value[g+1]),
            .i_up_age    (up_age[g+1]),
            .o_dn        (dn_link[g+1]),
            .o_dn_value  (dn_value[g+1]),
            .o_dn_age    (dn_age[g+1]),
            .o_up_valid  (up_valid[g]),
            .o_up_value  (up_value[g]),
            .o_up_age    (up_age[g]),
            .o_next_value(next_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill  <= n_fill;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_median <= next_value[mid[AW-1:0]];
        end
    end

    assign o_valid  = r_valid;
    assign o_median = r_median;

endmodule

@@ tb/running_median_filter_tb.sv @@
`timescale 1ns / 1ps

module running_median_filter_tb;
    import rmf_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int N_DIRECTED  = 23;
    localparam int N_RANDOM    = 1550;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [SW-1:0] MOST_NEG  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] MOST_POS  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] NEG_FLOOR = {1'b1, {(SW-2){1'b0}}, 1'b1};

    typedef struct packed {
        logic                 typed;
        logic signed [SW-1:0] median;
    } t_typed;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 typed;
        logic signed [SW-1:0] median;
    } t_row;

    // first rows see a partial window, so their medians are plain to read
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{MOST_NEG,     1'b1, NEG_FLOOR},
        '{MOST_POS,     1'b1, MOST_POS},
        '{16'sd0,       1'b1, 16'sd0},
        '{-16'sd1,      1'b0, 16'sd0},
        '{16'sd1,       1'b0, 16'sd0},
        '{16'sh5555,    1'b0, 16'sd0},
        '{-16'sh5556,   1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_POS,     1'b0, 16'sd0},
        '{16'sd7,       1'b0, 16'sd0},
        '{16'sd7,       1'b0, 16'sd0},
        '{16'sd7,       1'b0, 16'sd0},
        '{-16'sd7,      1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_NEG,     1'b0, 16'sd0},
        '{MOST_POS,     1'b0, 16'sd0}
    };

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 o_ready;
    logic signed [SW-1:0] i_sample = '0;
    logic                 o_valid;
    logic                 i_ready  = 1'b0;
    logic signed [SW-1:0] o_median;

    logic                 sample_taken = 1'b0;
    bit                   idle_on      = 1'b1;
    int                   errors       = 0;
    int                   cycle_count  = 0;

    logic signed [SW-1:0] window_q [WINDOW];
    int                   wr_pos   = 0;
    int                   fill_cnt = 0;

    t_typed               typed_q  [$];
    logic signed [SW-1:0] median_q [$];

    running_median_filter #(
        .WINDOW       (WINDOW),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_median (o_median)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [SW-1:0] next_median(input logic signed [SW-1:0] raw);
        logic signed [SW-1:0] sorted [WINDOW];
        logic signed [SW-1:0] v;
        int                   i;
        int                   j;
        // raise the most negative sample by one
        v = (raw == MOST_NEG) ? NEG_FLOOR : raw;
        window_q[wr_pos] = v;
        wr_pos = (wr_pos + 1) % WINDOW;
        if (fill_cnt < WINDOW) begin
            fill_cnt++;
        end
        for (i = 0; i < fill_cnt; i++) begin
            v = window_q[i];
            j = i;
            while (j > 0 && sorted[j > 0 ? j - 1 : 0] < v) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[(fill_cnt + 1) / 2 - 1];
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] s, input logic typed,
                               input logic signed [SW-1:0] m);
        t_typed t;
        t.typed  = typed;
        t.median = m;
        while (idle_on && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        typed_q.push_back(t);
        do @(negedge i_clk); while (!sample_taken);
    endtask

    always @(negedge i_clk) begin
        i_ready <= !idle_on || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge i_clk) begin
        t_typed               t;
        logic signed [SW-1:0] predicted;
        logic signed [SW-1:0] wanted;
        sample_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (median_q.size() == 0) begin
                    $display("%0t: median with nothing expected, expected none, got %0d",
                             $time, o_median);
                    errors++;
                end else begin
                    wanted = median_q.pop_front();
                    if (o_median !== wanted) begin
                        $display("%0t: median mismatch, expected %0d, got %0d",
                                 $time, wanted, o_median);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                t         = typed_q.pop_front();
                predicted = next_median(i_sample);
                median_q.push_back(t.typed ? t.median : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] prev;
        int                   mode;
        int                   b;
        prev = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_sample(DIRECTED_ROWS[n].sample, DIRECTED_ROWS[n].typed,
                        DIRECTED_ROWS[n].median);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = !(n >= 600 && n < 900);
            mode    = $urandom_range(0, 9);
            case (mode)
                0, 1, 2, 3: begin
                    s = SW'($urandom);
                end
                4, 5: begin
                    s = SW'($urandom_range(0, 16));
                    s = s - 16'sd8;
                end
                6: begin
                    s = prev;
                end
                7: begin
                    s = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
                end
                8: begin
                    s = SW'($urandom_range(0, 3));
                    s = $urandom_range(0, 1) ? MOST_POS - s : MOST_NEG + s;
                end
                default: begin
                    b = $urandom_range(0, SW - 1);
                    s = '0;
                    s[b] = 1'b1;
                    if ($urandom_range(0, 1)) begin
                        s = ~s;
                    end
                end
            endcase
            prev = s;
            send_sample(s, 1'b0, '0);
        end
        i_valid <= 1'b0;
        idle_on = 1'b1;

        while (median_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
